[hw/rtl/pis_pkg.sv]
// ----------------------------------------------------------------------------
// pis_pkg
// shared widths, register indexes, reset values and types for the pid block
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int DataW   = 16;
    localparam int ErrW    = 17;
    localparam int DiffW   = 18;
    localparam int LimW    = 15;
    localparam int FracW   = 16;
    localparam int IntegW  = 40;
    localparam int PropW   = 34;
    localparam int DerivW  = 35;
    localparam int PdW     = 36;
    localparam int SumW    = 42;
    localparam int CfgIdxW = 3;

    // register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_KP     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KI     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KD     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ILIM   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OLIM   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd6;

    localparam logic [DataW-1:0] RST_KP     = 16'd20480;
    localparam logic [DataW-1:0] RST_KI     = 16'd0;
    localparam logic [DataW-1:0] RST_KD     = 16'd0;
    localparam logic [LimW-1:0]  RST_ILIM   = 15'd2300;
    localparam logic [LimW-1:0]  RST_OLIM   = 15'd2500;
    localparam logic [LimW-1:0]  RST_THRESH = 15'd2560;
    localparam logic [DataW-1:0] RST_OFFSET = 16'hFF0F;   // -241

    typedef struct packed {
        logic [DataW-1:0]        kp;
        logic [DataW-1:0]        ki;
        logic [DataW-1:0]        kd;
        logic [LimW-1:0]         ilim;
        logic [LimW-1:0]         olim;
        logic [LimW-1:0]         thresh;
        logic signed [DataW-1:0] offset;
    } t_cfg;

    // pipeline advance and the valid bit of the stage feeding a module
    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

endpackage

[hw/rtl/pis_front.sv]
// ----------------------------------------------------------------------------
// pis_front
// error forming, saturation to 17 bits, separation test and error difference
// ----------------------------------------------------------------------------
module pis_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pis_pkg::t_stage_ctl                 i_ctl,
    input  pis_pkg::t_cfg                       i_cfg,
    input  logic signed [pis_pkg::DataW-1:0]    i_target,
    input  logic signed [pis_pkg::DataW-1:0]    i_measured,
    output logic signed [pis_pkg::ErrW-1:0]     o_err,
    output logic signed [pis_pkg::DiffW-1:0]    o_diff,
    output logic                                o_active
);

    logic signed [pis_pkg::DiffW-1:0] raw;
    logic signed [pis_pkg::ErrW-1:0]  err;
    logic        [pis_pkg::ErrW-1:0]  mag;
    logic                             active;
    logic signed [pis_pkg::DiffW-1:0] diff;

    logic signed [pis_pkg::ErrW-1:0]  r_prev;
    logic signed [pis_pkg::ErrW-1:0]  r_err;
    logic signed [pis_pkg::DiffW-1:0] r_diff;
    logic                             r_active;

    always_comb begin
        raw = pis_pkg::DiffW'(i_target) - pis_pkg::DiffW'(i_measured)
            - pis_pkg::DiffW'(i_cfg.offset);
        // clip into the 17-bit signed range
        if (raw[pis_pkg::DiffW-1] != raw[pis_pkg::DiffW-2]) begin
            err = raw[pis_pkg::DiffW-1] ? {1'b1, {(pis_pkg::ErrW-1){1'b0}}}
                                        : {1'b0, {(pis_pkg::ErrW-1){1'b1}}};
        end else begin
            err = raw[pis_pkg::ErrW-1:0];
        end
        mag    = err[pis_pkg::ErrW-1] ? (~err + 1'b1) : err;
        active = mag <= {2'b00, i_cfg.thresh};
        diff   = pis_pkg::DiffW'(err) - pis_pkg::DiffW'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctl.en && i_ctl.vld) begin
            r_prev <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_err    <= err;
            r_diff   <= diff;
            r_active <= active;
        end
    end

    assign o_err    = r_err;
    assign o_diff   = r_diff;
    assign o_active = r_active;

endmodule

[hw/rtl/pis_mult.sv]
// ----------------------------------------------------------------------------
// pis_mult
// the three gain products, each registered
// ----------------------------------------------------------------------------
module pis_mult (
    input  logic                                i_clk,
    input  pis_pkg::t_stage_ctl                 i_ctl,
    input  pis_pkg::t_cfg                       i_cfg,
    input  logic signed [pis_pkg::ErrW-1:0]     i_err,
    input  logic signed [pis_pkg::DiffW-1:0]    i_diff,
    input  logic                                i_active,
    output logic signed [pis_pkg::PropW-1:0]    o_p,
    output logic signed [pis_pkg::PropW-1:0]    o_i,
    output logic signed [pis_pkg::DerivW-1:0]   o_d,
    output logic                                o_active
);

    logic signed [pis_pkg::DataW:0]    kp_s;
    logic signed [pis_pkg::DataW:0]    ki_s;
    logic signed [pis_pkg::DataW:0]    kd_s;
    logic signed [pis_pkg::PropW-1:0]  p_prod;
    logic signed [pis_pkg::PropW-1:0]  i_prod;
    logic signed [pis_pkg::DerivW-1:0] d_prod;

    logic signed [pis_pkg::PropW-1:0]  r_p;
    logic signed [pis_pkg::PropW-1:0]  r_i;
    logic signed [pis_pkg::DerivW-1:0] r_d;
    logic                              r_active;

    always_comb begin
        kp_s   = {1'b0, i_cfg.kp};
        ki_s   = {1'b0, i_cfg.ki};
        kd_s   = {1'b0, i_cfg.kd};
        p_prod = pis_pkg::PropW'(kp_s) * pis_pkg::PropW'(i_err);
        i_prod = pis_pkg::PropW'(ki_s) * pis_pkg::PropW'(i_err);
        d_prod = pis_pkg::DerivW'(kd_s) * pis_pkg::DerivW'(i_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_p      <= p_prod;
            r_i      <= i_prod;
            r_d      <= d_prod;
            r_active <= i_active;
        end
    end

    assign o_p      = r_p;
    assign o_i      = r_i;
    assign o_d      = r_d;
    assign o_active = r_active;

endmodule

[hw/rtl/pis_accum.sv]
// ----------------------------------------------------------------------------
// pis_accum
// clamped integral accumulator and the partial sum of the p and d terms
// ----------------------------------------------------------------------------
module pis_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pis_pkg::t_stage_ctl                 i_ctl,
    input  pis_pkg::t_cfg                       i_cfg,
    input  logic signed [pis_pkg::PropW-1:0]    i_p,
    input  logic signed [pis_pkg::PropW-1:0]    i_i,
    input  logic signed [pis_pkg::DerivW-1:0]   i_d,
    input  logic                                i_active,
    output logic signed [pis_pkg::PdW-1:0]      o_pd,
    output logic signed [pis_pkg::IntegW-1:0]   o_isel,
    output logic                                o_active
);

    localparam int AccW = pis_pkg::IntegW + 1;

    logic signed [AccW-1:0]             acc;
    logic signed [AccW-1:0]             lim;
    logic signed [pis_pkg::IntegW-1:0]  integ_next;
    logic signed [pis_pkg::PdW-1:0]     pd;

    logic signed [pis_pkg::IntegW-1:0]  r_integ;
    logic signed [pis_pkg::PdW-1:0]     r_pd;
    logic signed [pis_pkg::IntegW-1:0]  r_isel;
    logic                               r_active;

    always_comb begin
        acc = AccW'(r_integ) + AccW'(i_i);
        lim = {{(AccW - pis_pkg::LimW - pis_pkg::FracW){1'b0}}, i_cfg.ilim,
               {pis_pkg::FracW{1'b0}}};
        if (acc > lim) begin
            integ_next = lim[pis_pkg::IntegW-1:0];
        end else if (acc < -lim) begin
            integ_next = pis_pkg::IntegW'(-lim);
        end else begin
            integ_next = acc[pis_pkg::IntegW-1:0];
        end
        pd = pis_pkg::PdW'(i_p) + pis_pkg::PdW'(i_d);
    end

    // integral is frozen while the error is outside the separation band
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctl.en && i_ctl.vld && i_active) begin
            r_integ <= integ_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_pd     <= pd;
            r_isel   <= i_active ? integ_next : '0;
            r_active <= i_active;
        end
    end

    assign o_pd     = r_pd;
    assign o_isel   = r_isel;
    assign o_active = r_active;

endmodule

[hw/rtl/pis_out.sv]
// ----------------------------------------------------------------------------
// pis_out
// final sum, truncation toward zero, output clamp and result register
// ----------------------------------------------------------------------------
module pis_out (
    input  logic                                i_clk,
    input  pis_pkg::t_stage_ctl                 i_ctl,
    input  pis_pkg::t_cfg                       i_cfg,
    input  logic signed [pis_pkg::PdW-1:0]      i_pd,
    input  logic signed [pis_pkg::IntegW-1:0]   i_isel,
    input  logic                                i_active,
    output logic signed [pis_pkg::DataW-1:0]    o_drive,
    output logic                                o_active,
    output logic                                o_sat
);

    localparam int QW = pis_pkg::SumW - pis_pkg::FracW;

    logic signed [pis_pkg::SumW-1:0] sum;
    logic signed [pis_pkg::SumW-1:0] olim_q;
    logic signed [QW-1:0]            olim_i;
    logic signed [QW-1:0]            q;
    logic                            sat;
    logic signed [QW-1:0]            drive_w;

    logic signed [pis_pkg::DataW-1:0] r_drive;
    logic                             r_active;
    logic                             r_sat;

    always_comb begin
        sum    = pis_pkg::SumW'(i_pd) + pis_pkg::SumW'(i_isel);
        olim_q = {{(pis_pkg::SumW - pis_pkg::LimW - pis_pkg::FracW){1'b0}}, i_cfg.olim,
                  {pis_pkg::FracW{1'b0}}};
        olim_i = {{(QW - pis_pkg::LimW){1'b0}}, i_cfg.olim};
        sat    = (sum > olim_q) || (sum < -olim_q);
        // round toward zero: a negative sum with a fraction moves up by one
        q = sum[pis_pkg::SumW-1:pis_pkg::FracW]
          + QW'(sum[pis_pkg::SumW-1] && (|sum[pis_pkg::FracW-1:0]));
        if (q > olim_i) begin
            drive_w = olim_i;
        end else if (q < -olim_i) begin
            drive_w = -olim_i;
        end else begin
            drive_w = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_drive  <= drive_w[pis_pkg::DataW-1:0];
            r_active <= i_active;
            r_sat    <= sat;
        end
    end

    assign o_drive  = r_drive;
    assign o_active = r_active;
    assign o_sat    = r_sat;

endmodule

[hw/rtl/pid_integral_separation_unit.sv]
// ----------------------------------------------------------------------------
// pid_integral_separation_unit
// positional pid step with integral separation, one sample per transfer
// ----------------------------------------------------------------------------
// the slave stream carries one sample per transfer: target and measured
// angle in signed q8.8. the master stream returns one result per sample:
// the saturated drive in tdata, integral_active and saturated in tuser.
// gains, limits, separation threshold and error offset sit behind a small
// write channel (index plus data, always ready); write them only while no
// sample is in flight.
// the datapath is a five-register pipeline: input register, error stage,
// gain multipliers, integral accumulator, output register. a new sample
// is taken every cycle unless the receiver stalls with a result waiting.
// the integral feedback closes inside the accumulator stage alone (one add
// and clamp), which is what allows one sample per cycle.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis tready drops; it never drops while the output register is empty.
// reset (synchronous, active low) empties the pipeline, zeroes the integral
// and the stored previous error and restores the register defaults.
// ----------------------------------------------------------------------------
module pid_integral_separation_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,  // [15:0] target, [31:16] measured
    // master stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [15:0]                      o_m_axis_tdata,  // [15:0] drive
    output logic [1:0]                       o_m_axis_tuser,  // [0] integral_active, [1] saturated
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pis_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [pis_pkg::DataW-1:0]        i_cfg_data
);

    logic                 en;
    logic                 in_fire;
    logic [4:0]           r_vld;
    pis_pkg::t_cfg        r_cfg;

    logic signed [pis_pkg::DataW-1:0]  r_target;
    logic signed [pis_pkg::DataW-1:0]  r_measured;

    logic signed [pis_pkg::ErrW-1:0]   f_err;
    logic signed [pis_pkg::DiffW-1:0]  f_diff;
    logic                              f_active;
    logic signed [pis_pkg::PropW-1:0]  m_p;
    logic signed [pis_pkg::PropW-1:0]  m_i;
    logic signed [pis_pkg::DerivW-1:0] m_d;
    logic                              m_active;
    logic signed [pis_pkg::PdW-1:0]    a_pd;
    logic signed [pis_pkg::IntegW-1:0] a_isel;
    logic                              a_active;
    logic signed [pis_pkg::DataW-1:0]  o_drive_w;
    logic                              o_active_w;
    logic                              o_sat_w;

    pis_pkg::t_stage_ctl ctl_front;
    pis_pkg::t_stage_ctl ctl_mult;
    pis_pkg::t_stage_ctl ctl_accum;
    pis_pkg::t_stage_ctl ctl_out;

    logic [pis_pkg::DataW-1:0] lim_pos;
    logic [pis_pkg::DataW-1:0] lim_neg;

    // whole pipeline advances together unless a result waits on the receiver
    assign en              = !r_vld[4] || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    assign ctl_front = '{en: en, vld: r_vld[0]};
    assign ctl_mult  = '{en: en, vld: r_vld[1]};
    assign ctl_accum = '{en: en, vld: r_vld[2]};
    assign ctl_out   = '{en: en, vld: r_vld[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], in_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_target   <= i_s_axis_tdata[15:0];
            r_measured <= i_s_axis_tdata[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp     <= pis_pkg::RST_KP;
            r_cfg.ki     <= pis_pkg::RST_KI;
            r_cfg.kd     <= pis_pkg::RST_KD;
            r_cfg.ilim   <= pis_pkg::RST_ILIM;
            r_cfg.olim   <= pis_pkg::RST_OLIM;
            r_cfg.thresh <= pis_pkg::RST_THRESH;
            r_cfg.offset <= pis_pkg::RST_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pis_pkg::REG_KP:     r_cfg.kp     <= i_cfg_data;
                pis_pkg::REG_KI:     r_cfg.ki     <= i_cfg_data;
                pis_pkg::REG_KD:     r_cfg.kd     <= i_cfg_data;
                pis_pkg::REG_ILIM:   r_cfg.ilim   <= i_cfg_data[pis_pkg::LimW-1:0];
                pis_pkg::REG_OLIM:   r_cfg.olim   <= i_cfg_data[pis_pkg::LimW-1:0];
                pis_pkg::REG_THRESH: r_cfg.thresh <= i_cfg_data[pis_pkg::LimW-1:0];
                pis_pkg::REG_OFFSET: r_cfg.offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_front),
        .i_cfg      (r_cfg),
        .i_target   (r_target),
        .i_measured (r_measured),
        .o_err      (f_err),
        .o_diff     (f_diff),
        .o_active   (f_active)
    );

    pis_mult u_mult (
        .i_clk    (i_clk),
        .i_ctl    (ctl_mult),
        .i_cfg    (r_cfg),
        .i_err    (f_err),
        .i_diff   (f_diff),
        .i_active (f_active),
        .o_p      (m_p),
        .o_i      (m_i),
        .o_d      (m_d),
        .o_active (m_active)
    );

    pis_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_accum),
        .i_cfg    (r_cfg),
        .i_p      (m_p),
        .i_i      (m_i),
        .i_d      (m_d),
        .i_active (m_active),
        .o_pd     (a_pd),
        .o_isel   (a_isel),
        .o_active (a_active)
    );

    pis_out u_out (
        .i_clk    (i_clk),
        .i_ctl    (ctl_out),
        .i_cfg    (r_cfg),
        .i_pd     (a_pd),
        .i_isel   (a_isel),
        .i_active (a_active),
        .o_drive  (o_drive_w),
        .o_active (o_active_w),
        .o_sat    (o_sat_w)
    );

    assign o_m_axis_tvalid = r_vld[4];
    assign o_m_axis_tdata  = o_drive_w;
    assign o_m_axis_tuser  = {o_sat_w, o_active_w};

    assign lim_pos = {1'b0, r_cfg.olim};
    assign lim_neg = -lim_pos;

    // a flagged result sits exactly on one of the two drive limits
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
            (o_m_axis_tdata == lim_pos || o_m_axis_tdata == lim_neg))
        else $error("saturated result not at drive limit");

    // an accepted sample always lands in the input register
    a_fill_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted sample lost at input register");

    // with the output register empty the pipeline never back-pressures
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

endmodule
